### hdl/swb_pkg.sv
// Shared types and constants for the single-wire bus master.
// Used by swb_core and single_wire_bus_master_top; no dependencies.
package swb_pkg;

    localparam int unsigned TimeW    = 10;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned BitIdxW  = 3;
    localparam int unsigned NumRegs  = 8;
    localparam int unsigned RegIdxW  = 3;

    // Command codes on the input tuser field
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_RESET = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    // Configuration register indexes
    typedef enum logic [RegIdxW-1:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_RESET_TAIL    = 3'd2,
        REG_WRITE_LOW     = 3'd3,
        REG_WRITE_SLOT    = 3'd4,
        REG_BYTE_RECOVERY = 3'd5,
        REG_READ_LOW      = 3'd6,
        REG_READ_SAMPLE   = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_WR_LOW   = 4'd4,
        PH_WR_REST  = 4'd5,
        PH_WR_RECOV = 4'd6,
        PH_RD_LOW   = 4'd7,
        PH_RD_WAIT  = 4'd8,
        PH_RD_TAIL  = 4'd9
    } phase_t;

    localparam logic [TimeW-1:0] RESET_LOW_DEF     = 10'd500;
    localparam logic [TimeW-1:0] PRESENCE_WAIT_DEF = 10'd30;
    localparam logic [TimeW-1:0] RESET_TAIL_DEF    = 10'd470;
    localparam logic [TimeW-1:0] WRITE_LOW_DEF     = 10'd5;
    localparam logic [TimeW-1:0] WRITE_SLOT_DEF    = 10'd80;
    localparam logic [TimeW-1:0] BYTE_RECOVERY_DEF = 10'd100;
    localparam logic [TimeW-1:0] READ_LOW_DEF      = 10'd3;
    localparam logic [TimeW-1:0] READ_SAMPLE_DEF   = 10'd10;

    typedef struct packed {
        logic [TimeW-1:0] reset_low_us;
        logic [TimeW-1:0] presence_wait_us;
        logic [TimeW-1:0] reset_tail_us;
        logic [TimeW-1:0] write_low_us;
        logic [TimeW-1:0] write_slot_us;
        logic [TimeW-1:0] byte_recovery_us;
        logic [TimeW-1:0] read_low_us;
        logic [TimeW-1:0] read_sample_us;
    } cfg_t;

    typedef struct packed {
        logic [ByteW-1:0] read_data;
        logic             presence;
        logic             done_res;
        logic             busy_res;
        logic             drive_low;
    } result_t;

    // A zero duration counts as one microsecond
    function automatic logic [TimeW-1:0] load_time(input logic [TimeW-1:0] us);
        load_time = (us == '0) ? TimeW'(1) : us;
    endfunction

endpackage

### hdl/swb_core.sv
// Bus timing sequencer: phase machine, slot timer, bit shifter and flags.
// Depends on swb_pkg; state advances on each accepted item.
module swb_core #(
    parameter logic [swb_pkg::TimeW-1:0] READ_TAIL_US = 10'd53
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  swb_pkg::func_t              func,
    input  logic [swb_pkg::ByteW-1:0]   write_data,
    input  logic                        line_level,
    input  swb_pkg::cfg_t               cfg,
    output swb_pkg::result_t            res
);

    swb_pkg::phase_t                   phase_reg, phase_next;
    logic [swb_pkg::TimeW-1:0]         slot_timer_reg, slot_timer_next;
    logic [swb_pkg::BitIdxW-1:0]       bit_index_reg, bit_index_next;
    logic [swb_pkg::ByteW-1:0]         shift_byte_reg, shift_byte_next;
    logic                              first_low_reg, first_low_next;
    logic                              presence_reg, presence_next;
    logic [swb_pkg::ByteW-1:0]         read_result_reg, read_result_next;
    logic                              start, phase_end, last_bit, recov_zero;

    assign start      = accept && (phase_reg == swb_pkg::PH_IDLE);
    assign phase_end  = accept && (phase_reg != swb_pkg::PH_IDLE)
                        && (func == swb_pkg::FUNC_TICK) && (slot_timer_reg <= 10'd1);
    assign last_bit   = (bit_index_reg == '1);
    assign recov_zero = (cfg.byte_recovery_us == '0);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (start) begin
            unique case (func)
                swb_pkg::FUNC_RESET: phase_next = swb_pkg::PH_RST_LOW;
                swb_pkg::FUNC_WRITE: phase_next = swb_pkg::PH_WR_LOW;
                swb_pkg::FUNC_READ:  phase_next = swb_pkg::PH_RD_LOW;
                default:             phase_next = swb_pkg::PH_IDLE;
            endcase
        end else if (phase_end) begin
            unique case (phase_reg)
                swb_pkg::PH_RST_LOW:  phase_next = swb_pkg::PH_RST_WAIT;
                swb_pkg::PH_RST_WAIT: phase_next = swb_pkg::PH_RST_TAIL;
                swb_pkg::PH_WR_LOW:   phase_next = swb_pkg::PH_WR_REST;
                swb_pkg::PH_WR_REST: begin
                    if (!last_bit)
                        phase_next = swb_pkg::PH_WR_LOW;
                    else if (recov_zero)
                        phase_next = swb_pkg::PH_IDLE;
                    else
                        phase_next = swb_pkg::PH_WR_RECOV;
                end
                swb_pkg::PH_RD_LOW:   phase_next = swb_pkg::PH_RD_WAIT;
                swb_pkg::PH_RD_WAIT:  phase_next = swb_pkg::PH_RD_TAIL;
                swb_pkg::PH_RD_TAIL:
                    phase_next = last_bit ? swb_pkg::PH_IDLE : swb_pkg::PH_RD_LOW;
                default:              phase_next = swb_pkg::PH_IDLE;
            endcase
        end
    end

    // Timer, shifter, flags and result fields
    always_comb begin
        slot_timer_next  = slot_timer_reg;
        bit_index_next   = bit_index_reg;
        shift_byte_next  = shift_byte_reg;
        first_low_next   = first_low_reg;
        presence_next    = presence_reg;
        read_result_next = read_result_reg;
        res.done_res     = 1'b0;

        if (start) begin
            unique case (func)
                swb_pkg::FUNC_RESET: begin
                    first_low_next  = 1'b0;
                    slot_timer_next = swb_pkg::load_time(cfg.reset_low_us);
                end
                swb_pkg::FUNC_WRITE: begin
                    shift_byte_next = write_data;
                    bit_index_next  = '0;
                    slot_timer_next = swb_pkg::load_time(cfg.write_low_us);
                end
                swb_pkg::FUNC_READ: begin
                    shift_byte_next = '0;
                    bit_index_next  = '0;
                    slot_timer_next = swb_pkg::load_time(cfg.read_low_us);
                end
                default: ;
            endcase
        end else if (accept && (phase_reg != swb_pkg::PH_IDLE)
                     && (func == swb_pkg::FUNC_TICK) && !phase_end) begin
            slot_timer_next = slot_timer_reg - 10'd1;
        end else if (phase_end) begin
            unique case (phase_reg)
                swb_pkg::PH_RST_LOW:
                    slot_timer_next = swb_pkg::load_time(cfg.presence_wait_us);
                swb_pkg::PH_RST_WAIT: begin
                    first_low_next  = !line_level;
                    slot_timer_next = swb_pkg::load_time(cfg.reset_tail_us);
                end
                swb_pkg::PH_RST_TAIL: begin
                    presence_next = first_low_reg && line_level;
                    res.done_res  = 1'b1;
                end
                swb_pkg::PH_WR_LOW:
                    slot_timer_next = swb_pkg::load_time(cfg.write_slot_us);
                swb_pkg::PH_WR_REST: begin
                    if (!last_bit) begin
                        bit_index_next  = bit_index_reg + 3'd1;
                        slot_timer_next = swb_pkg::load_time(cfg.write_low_us);
                    end else if (recov_zero) begin
                        res.done_res = 1'b1;
                    end else begin
                        slot_timer_next = cfg.byte_recovery_us;
                    end
                end
                swb_pkg::PH_WR_RECOV:
                    res.done_res = 1'b1;
                swb_pkg::PH_RD_LOW:
                    slot_timer_next = swb_pkg::load_time(cfg.read_sample_us);
                swb_pkg::PH_RD_WAIT: begin
                    if (line_level)
                        shift_byte_next[bit_index_reg] = 1'b1;
                    slot_timer_next = swb_pkg::load_time(READ_TAIL_US);
                end
                swb_pkg::PH_RD_TAIL: begin
                    if (!last_bit) begin
                        bit_index_next  = bit_index_reg + 3'd1;
                        slot_timer_next = swb_pkg::load_time(cfg.read_low_us);
                    end else begin
                        read_result_next = shift_byte_reg;
                        res.done_res     = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // Pull the line during low pulses and for a zero bit of a write slot
        res.drive_low = (phase_next == swb_pkg::PH_RST_LOW)
                     || (phase_next == swb_pkg::PH_WR_LOW)
                     || (phase_next == swb_pkg::PH_RD_LOW)
                     || ((phase_next == swb_pkg::PH_WR_REST)
                         && !shift_byte_next[bit_index_next]);
        res.busy_res  = (phase_next != swb_pkg::PH_IDLE);
        res.presence  = presence_next;
        res.read_data = read_result_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= swb_pkg::PH_IDLE;
            slot_timer_reg  <= '0;
            bit_index_reg   <= '0;
            shift_byte_reg  <= '0;
            first_low_reg   <= 1'b0;
            presence_reg    <= 1'b0;
            read_result_reg <= '0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            slot_timer_reg  <= slot_timer_next;
            bit_index_reg   <= bit_index_next;
            shift_byte_reg  <= shift_byte_next;
            first_low_reg   <= first_low_next;
            presence_reg    <= presence_next;
            read_result_reg <= read_result_next;
        end
    end

endmodule

### hdl/single_wire_bus_master_top.sv
// Single-wire bus master top level: APB register file, sequencer, output stage.
// Depends on swb_pkg and swb_core.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------------
//   s_       | in        | tuser: func; tdata: write_data, line_level
//   m_       | out       | tdata: drive_low, busy_res, done_res, presence, read_data
//   APB      | in/out    | eight 10-bit timing registers at byte offsets 0..28
//
// One item per clock while s_tready is high: each accepted item updates the sequencer state in the
// cycle it is taken and its result is registered in the output stage or its skid register.
// A skid register behind the output stage keeps s_tready high for one more
// item while m_tready is low; s_tready drops only when both hold items.
// Reset (aresetn low, synchronous) idles the sequencer, empties the output
// stage and loads the default timing registers.
module single_wire_bus_master_top #(
    parameter logic [9:0] READ_TAIL_US = 10'd53
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,    // [1:0] func
    input  logic [15:0] s_tdata,    // [7:0] write_data, [8] line_level, [15:9] zero
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [0] drive_low, [1] busy_res, [2] done_res,
                                    // [3] presence, [11:4] read_data, [15:12] zero
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    swb_pkg::cfg_t     cfg_reg;
    swb_pkg::result_t  core_res;
    swb_pkg::result_t  out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;
    logic              accept, out_take, cfg_wr;
    logic [swb_pkg::RegIdxW-1:0] reg_idx;
    logic [swb_pkg::TimeW-1:0]   rd_val;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_us     <= swb_pkg::RESET_LOW_DEF;
            cfg_reg.presence_wait_us <= swb_pkg::PRESENCE_WAIT_DEF;
            cfg_reg.reset_tail_us    <= swb_pkg::RESET_TAIL_DEF;
            cfg_reg.write_low_us     <= swb_pkg::WRITE_LOW_DEF;
            cfg_reg.write_slot_us    <= swb_pkg::WRITE_SLOT_DEF;
            cfg_reg.byte_recovery_us <= swb_pkg::BYTE_RECOVERY_DEF;
            cfg_reg.read_low_us      <= swb_pkg::READ_LOW_DEF;
            cfg_reg.read_sample_us   <= swb_pkg::READ_SAMPLE_DEF;
        end else if (cfg_wr) begin
            unique case (swb_pkg::reg_idx_t'(reg_idx))
                swb_pkg::REG_RESET_LOW:     cfg_reg.reset_low_us     <= pwdata[9:0];
                swb_pkg::REG_PRESENCE_WAIT: cfg_reg.presence_wait_us <= pwdata[9:0];
                swb_pkg::REG_RESET_TAIL:    cfg_reg.reset_tail_us    <= pwdata[9:0];
                swb_pkg::REG_WRITE_LOW:     cfg_reg.write_low_us     <= pwdata[9:0];
                swb_pkg::REG_WRITE_SLOT:    cfg_reg.write_slot_us    <= pwdata[9:0];
                swb_pkg::REG_BYTE_RECOVERY: cfg_reg.byte_recovery_us <= pwdata[9:0];
                swb_pkg::REG_READ_LOW:      cfg_reg.read_low_us      <= pwdata[9:0];
                swb_pkg::REG_READ_SAMPLE:   cfg_reg.read_sample_us   <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (swb_pkg::reg_idx_t'(reg_idx))
            swb_pkg::REG_RESET_LOW:     rd_val = cfg_reg.reset_low_us;
            swb_pkg::REG_PRESENCE_WAIT: rd_val = cfg_reg.presence_wait_us;
            swb_pkg::REG_RESET_TAIL:    rd_val = cfg_reg.reset_tail_us;
            swb_pkg::REG_WRITE_LOW:     rd_val = cfg_reg.write_low_us;
            swb_pkg::REG_WRITE_SLOT:    rd_val = cfg_reg.write_slot_us;
            swb_pkg::REG_BYTE_RECOVERY: rd_val = cfg_reg.byte_recovery_us;
            swb_pkg::REG_READ_LOW:      rd_val = cfg_reg.read_low_us;
            swb_pkg::REG_READ_SAMPLE:   rd_val = cfg_reg.read_sample_us;
            default:                    rd_val = '0;
        endcase
    end

    assign prdata = {22'd0, rd_val};

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;

    swb_core #(
        .READ_TAIL_US (READ_TAIL_US)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .func       (swb_pkg::func_t'(s_tuser)),
        .write_data (s_tdata[7:0]),
        .line_level (s_tdata[8]),
        .cfg        (cfg_reg),
        .res        (core_res)
    );

    // Output register with skid: refill from skid first to keep item order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_take || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take || !out_valid_reg) begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= core_res;
        end else if (accept) begin
            skid_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.read_data, out_reg.presence, out_reg.done_res,
                       out_reg.busy_res, out_reg.drive_low};

endmodule
